// File: sv/skt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH_DEF = 128;

    localparam int KEY_W  = 16;
    localparam int DUR_W  = 16;
    localparam int PAY_W  = 32;
    localparam int POS_W  = 7;
    localparam int SIZE_W = 8;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_MODIFY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] dur;
        logic [PAY_W-1:0] pay;
    } entry_t;

endpackage
`default_nettype wire

// File: sv/sorted_key_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of unique keys held in one synchronous memory. Binary search
// for lookup, insert with shift up, delete with shift down, dur/pay modify.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                          Direction
//  -------  -----------------------------------------------  ---------
//  in       in_valid, in_stall, command, search_key,          into block
//           new_duration, new_payload
//  out      out_valid, out_stall, status, position,           out of block
//           found_duration, found_payload, table_size
//
//  One item is worked on at a time; memory reads are registered. Each probe
//  of the binary search reads the middle entry (S_SRCH) and then compares its
//  key (S_CMP); the result is registered in S_DONE, and the next item is taken
//  only once the engine is back in S_IDLE.
//  Insert and delete move one entry at a time through the single read port,
//  each shift a read (S_SH_RD) then a write (S_SH_WR); an insert ends by
//  writing the new entry (S_PUT).
//  Reset empties the table at once; no clearing pass is needed.
//  A waiting result sits in the output register, so the next item is taken
//  while out_stall is high; the engine then holds in its final state.
//
module sorted_key_table #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  [1:0]                 command,
    input  wire  [skt_pkg::KEY_W-1:0]  search_key,
    input  wire  [skt_pkg::DUR_W-1:0]  new_duration,
    input  wire  [skt_pkg::PAY_W-1:0]  new_payload,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic [1:0]                 status,
    output logic [skt_pkg::POS_W-1:0]  position,
    output logic [skt_pkg::DUR_W-1:0]  found_duration,
    output logic [skt_pkg::PAY_W-1:0]  found_payload,
    output logic [skt_pkg::SIZE_W-1:0] table_size
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Entry memory
    skt_pkg::entry_t mem [DEPTH];
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    skt_pkg::entry_t rd_q_reg;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    skt_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Control and working registers
    skt_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    skt_pkg::cmd_t    cmd_reg, cmd_next;
    logic [skt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [skt_pkg::DUR_W-1:0] dur_reg, dur_next;
    logic [skt_pkg::PAY_W-1:0] pay_reg, pay_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    skt_pkg::entry_t  hent_reg, hent_next;

    skt_pkg::status_t res_status_reg, res_status_next;
    logic [IW-1:0]    res_pos_reg, res_pos_next;
    logic [skt_pkg::DUR_W-1:0] res_dur_reg, res_dur_next;
    logic [skt_pkg::PAY_W-1:0] res_pay_reg, res_pay_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_load;
    skt_pkg::status_t out_status_reg;
    logic [IW-1:0]    out_pos_reg;
    logic [skt_pkg::DUR_W-1:0] out_dur_reg;
    logic [skt_pkg::PAY_W-1:0] out_pay_reg;
    logic [CW-1:0]    out_size_reg;

    logic [CW-1:0]    mid;
    logic [CW-1:0]    diff;
    logic [CW-1:0]    ptr_dec;
    logic [CW-1:0]    ptr_inc;
    logic             hit;

    always_comb
    begin
        diff    = hi_reg - lo_reg;
        mid     = lo_reg + (diff >> 1);
        ptr_dec = ptr_reg - CW'(1);
        ptr_inc = ptr_reg + CW'(1);
        // The last probe that pulled hi down read the entry at the final
        // lower bound, so its key tells whether the search hit.
        hit     = (lo_reg < count_reg) && (hent_reg.key == key_reg);

        state_next      = state_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        dur_next        = dur_reg;
        pay_next        = pay_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ptr_next        = ptr_reg;
        hent_next       = hent_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_dur_next    = res_dur_reg;
        res_pay_next    = res_pay_reg;
        rd_en           = 1'b0;
        rd_addr         = mid[IW-1:0];
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[IW-1:0];
        wr_data         = rd_q_reg;
        out_load        = 1'b0;
        in_stall        = (state_reg != skt_pkg::S_IDLE);

        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = skt_pkg::cmd_t'(command);
                    key_next = search_key;
                    dur_next = new_duration;
                    pay_next = new_payload;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    if ((skt_pkg::cmd_t'(command) == skt_pkg::CMD_INSERT)
                        && (count_reg >= CW'(DEPTH)))
                    begin
                        res_status_next = skt_pkg::ST_FULL;
                        res_pos_next    = '0;
                        res_dur_next    = '0;
                        res_pay_next    = '0;
                        state_next      = skt_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = skt_pkg::S_SRCH;
                    end
                end
            end

            skt_pkg::S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[IW-1:0];
                    ptr_next   = mid;
                    state_next = skt_pkg::S_CMP;
                end
                else
                begin
                    state_next = skt_pkg::S_DECIDE;
                end
            end

            skt_pkg::S_CMP:
            begin
                if (rd_q_reg.key < key_reg)
                begin
                    lo_next = ptr_inc;
                end
                else
                begin
                    hi_next   = ptr_reg;
                    hent_next = rd_q_reg;
                end
                state_next = skt_pkg::S_SRCH;
            end

            skt_pkg::S_DECIDE:
            begin
                res_pos_next = lo_reg[IW-1:0];
                if (cmd_reg == skt_pkg::CMD_INSERT)
                begin
                    if (hit)
                    begin
                        res_status_next = skt_pkg::ST_DUPLICATE;
                        res_dur_next    = hent_reg.dur;
                        res_pay_next    = hent_reg.pay;
                        state_next      = skt_pkg::S_DONE;
                    end
                    else
                    begin
                        res_status_next = skt_pkg::ST_OK;
                        res_dur_next    = '0;
                        res_pay_next    = '0;
                        ptr_next        = count_reg;
                        state_next      = (count_reg > lo_reg) ? skt_pkg::S_SH_RD
                                                               : skt_pkg::S_PUT;
                    end
                end
                else if (!hit)
                begin
                    res_status_next = skt_pkg::ST_NOT_FOUND;
                    res_pos_next    = '0;
                    res_dur_next    = '0;
                    res_pay_next    = '0;
                    state_next      = skt_pkg::S_DONE;
                end
                else
                begin
                    res_status_next = skt_pkg::ST_OK;
                    res_dur_next    = hent_reg.dur;
                    res_pay_next    = hent_reg.pay;
                    state_next      = skt_pkg::S_DONE;
                    if (cmd_reg == skt_pkg::CMD_MODIFY)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = lo_reg[IW-1:0];
                        wr_data.key  = key_reg;
                        wr_data.dur  = dur_reg;
                        wr_data.pay  = pay_reg;
                    end
                    else if (cmd_reg == skt_pkg::CMD_DELETE)
                    begin
                        ptr_next = lo_reg;
                        if ((lo_reg + CW'(1)) < count_reg)
                        begin
                            state_next = skt_pkg::S_SH_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end

            skt_pkg::S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = (cmd_reg == skt_pkg::CMD_INSERT) ? ptr_dec[IW-1:0]
                                                              : ptr_inc[IW-1:0];
                state_next = skt_pkg::S_SH_WR;
            end

            skt_pkg::S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[IW-1:0];
                wr_data = rd_q_reg;
                if (cmd_reg == skt_pkg::CMD_INSERT)
                begin
                    ptr_next   = ptr_dec;
                    state_next = (ptr_dec > lo_reg) ? skt_pkg::S_SH_RD : skt_pkg::S_PUT;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    if ((ptr_inc + CW'(1)) < count_reg)
                    begin
                        state_next = skt_pkg::S_SH_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = skt_pkg::S_DONE;
                    end
                end
            end

            skt_pkg::S_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = lo_reg[IW-1:0];
                wr_data.key = key_reg;
                wr_data.dur = dur_reg;
                wr_data.pay = pay_reg;
                count_next  = count_reg + CW'(1);
                state_next  = skt_pkg::S_DONE;
            end

            skt_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = skt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        dur_reg        <= dur_next;
        pay_reg        <= pay_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        ptr_reg        <= ptr_next;
        hent_reg       <= hent_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_dur_reg    <= res_dur_next;
        res_pay_reg    <= res_pay_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_dur_reg    <= res_dur_reg;
            out_pay_reg    <= res_pay_reg;
            out_size_reg   <= count_reg;
        end
    end

    logic [IW+skt_pkg::POS_W-1:0]  pos_wide;
    logic [CW+skt_pkg::SIZE_W-1:0] size_wide;

    assign pos_wide       = {{skt_pkg::POS_W{1'b0}}, out_pos_reg};
    assign size_wide      = {{skt_pkg::SIZE_W{1'b0}}, out_size_reg};
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign position       = pos_wide[skt_pkg::POS_W-1:0];
    assign found_duration = out_dur_reg;
    assign found_payload  = out_pay_reg;
    assign table_size     = size_wide[skt_pkg::SIZE_W-1:0];

    // Assertions

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the table depth");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skt_pkg::S_IDLE) |-> !wr_en)
        else $error("memory written while no item is in progress");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1))
             || (count_reg == $past(count_reg) - CW'(1))))
        else $error("entry count moved by more than one");

    a_count_when: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == skt_pkg::S_DONE))
        else $error("entry count changed outside the end of a command");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == skt_pkg::S_DONE))
        else $error("result raised without a finished command");

endmodule
`default_nettype wire
